// ----- design/imu_complementary_tilt_filter_macros.svh -----
// ============================================================================
// Assertion macros for the complementary tilt filter
// Shared property wrappers; compiled out when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define ICTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ictf: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ICTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ictf: next-cycle check failed");

`else

`define ICTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ICTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/ictf_pkg.sv -----
// ============================================================================
// ictf_pkg
// Widths, types, constants and the arctangent table of the tilt filter.
// ============================================================================
package ictf_pkg;

    // Stream and register port widths
    localparam int IN_W        = 16;
    localparam int IN_TDATA_W  = 5 * IN_W;
    localparam int ANG_W       = 24;
    localparam int OUT_TDATA_W = 2 * ANG_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_W       = 16;

    // Register indexes, decoded from address bit 2
    localparam logic REG_GYRO_SCALE   = 1'b0;
    localparam logic REG_BLEND_WEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] GYRO_SCALE_RST   = 16'd1311;
    localparam logic [CFG_W-1:0] BLEND_WEIGHT_RST = 16'd64225;

    // Square root unit
    localparam int SUM_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int SQRT_ITER  = 16;
    localparam int SQRT_CNT_W = 4;

    // CORDIC unit
    localparam int TABLE_LEN  = 24;
    localparam int TBL_IDX_W  = 5;
    localparam int CIN_W      = 18;
    localparam int XY_W       = 34;
    localparam int Z_W        = 26;
    localparam int PRE_SHIFT  = 14;
    localparam int Q16_FRAC   = 16;

    // Shared multiplier and blend datapath
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int G_W     = 37;
    localparam int D_W     = 38;
    localparam int D_LO_W  = 19;
    localparam int MIX_W   = 56;

    localparam int ANG_MAX = 8388607;
    localparam int ANG_MIN = -8388608;

    typedef logic signed [Z_W-1:0]   t_angle;
    typedef logic signed [CIN_W-1:0] t_cordic_in;
    typedef logic signed [ANG_W-1:0] t_est;

    // atan(2^-i) in degrees, Q.16
    function automatic t_angle atan_q16(input logic [TBL_IDX_W-1:0] idx);
        t_angle v;
        unique case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/ictf_isqrt.sv -----
// ============================================================================
// ictf_isqrt
// Floor integer square root of a 32-bit value, two radicand bits per cycle.
// ============================================================================
module ictf_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ictf_pkg::SUM_W-1:0]   i_value,
    output logic                         o_done,
    output logic [ictf_pkg::ROOT_W-1:0]  o_root
);
    import ictf_pkg::*;

    localparam logic [SQRT_CNT_W-1:0] LAST = SQRT_CNT_W'(SQRT_ITER - 1);

    logic [SUM_W-1:0]      r_v;
    logic [SUM_W-1:0]      r_res;
    logic [SUM_W-1:0]      r_bit;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [SUM_W-1:0]      w_trial;

    // Trial subtrahend for the current bit pair
    assign w_trial = r_res + r_bit;

    // One restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + SQRT_CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ----- design/ictf_cordic.sv -----
// ============================================================================
// ictf_cordic
// Iterative CORDIC vectoring unit returning atan2(y, x) in Q.16 degrees.
// ============================================================================
module ictf_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  ictf_pkg::t_cordic_in     i_y,
    input  ictf_pkg::t_cordic_in     i_x,
    output logic                     o_done,
    output ictf_pkg::t_angle         o_angle
);
    import ictf_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam logic [TBL_IDX_W-1:0] LAST = TBL_IDX_W'(NSTEPS - 1);
    localparam t_angle QUARTER_TURN = Z_W'(90 * 65536);

    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    t_angle                 r_z;
    logic [TBL_IDX_W-1:0]   r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic signed [XY_W-1:0] w_xs_in;
    logic signed [XY_W-1:0] w_ys_in;
    logic signed [XY_W-1:0] w_x0;
    logic signed [XY_W-1:0] w_y0;
    t_angle                 w_z0;
    logic                   w_zero;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;

    // Scale the operands and turn a left-half-plane vector by a quarter turn
    always_comb begin
        w_xs_in = XY_W'(i_x) <<< PRE_SHIFT;
        w_ys_in = XY_W'(i_y) <<< PRE_SHIFT;
        w_x0    = w_xs_in;
        w_y0    = w_ys_in;
        w_z0    = '0;
        if (i_x[CIN_W-1]) begin
            if (!i_y[CIN_W-1]) begin
                w_x0 = w_ys_in;
                w_y0 = -w_xs_in;
                w_z0 = QUARTER_TURN;
            end else begin
                w_x0 = -w_ys_in;
                w_y0 = w_xs_in;
                w_z0 = -QUARTER_TURN;
            end
        end
    end

    assign w_zero = (i_x == '0) && (i_y == '0);

    // Floor shifts of the current vector
    assign w_xs = r_x >>> r_cnt;
    assign w_ys = r_y >>> r_cnt;

    // Micro-rotation sequencer: one step per cycle toward y = 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_zero) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_x    <= w_x0;
                    r_y    <= w_y0;
                    r_z    <= w_z0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (!r_y[XY_W-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + atan_q16(r_cnt);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - atan_q16(r_cnt);
                end
                r_cnt <= r_cnt + TBL_IDX_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

endmodule

// ----- design/imu_complementary_tilt_filter.sv -----
// A new sample is taken only in idle, once the previous result is in the output
// register; the shared CORDIC unit runs the roll vectoring and then, once the
// square root is known, the pitch vectoring.
// Reset (synchronous, active low) clears both angle estimates, the sequencer
// and the output valid, and loads the register defaults.
// ============================================================================
// imu_complementary_tilt_filter
// Complementary pitch/roll filter: accelerometer tilt by CORDIC, blended
// with the gyro-integrated estimate under a shared multiplier and sequencer.
// ============================================================================
`include "imu_complementary_tilt_filter_macros.svh"

module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample request
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y (16 bits each, lowest first)
    input  logic [ictf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Result request
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pitch_angle, roll_angle (24 bits each, lowest first)
    output logic [ictf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ictf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ictf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ictf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ictf_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_PITCH = 3'd3;
    localparam logic [2:0] S_DIFF  = 3'd4;
    localparam logic [2:0] S_BLEND = 3'd5;
    localparam logic [2:0] S_ROUND = 3'd6;

    // Multiplier operations, {blend phase, step}
    localparam logic [2:0] MOP_AX_SQ    = 3'd0;
    localparam logic [2:0] MOP_AZ_SQ    = 3'd1;
    localparam logic [2:0] MOP_GY_SCALE = 3'd2;
    localparam logic [2:0] MOP_GX_SCALE = 3'd3;
    localparam logic [2:0] MOP_DL_PITCH = 3'd4;
    localparam logic [2:0] MOP_DH_PITCH = 3'd5;
    localparam logic [2:0] MOP_DL_ROLL  = 3'd6;
    localparam logic [2:0] MOP_DH_ROLL  = 3'd7;

    localparam logic [2:0] MAC_LAST = 3'd4;

    localparam int GYRO_SHIFT = Q16_FRAC - ANGLE_FRAC_BITS;
    localparam int RND_SH     = 2 * Q16_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [MIX_W-1:0] RND_HALF = MIX_W'(1) <<< (RND_SH - 1);
    localparam logic signed [MIX_W-1:0] SAT_HI   = MIX_W'(ANG_MAX);
    localparam logic signed [MIX_W-1:0] SAT_LO   = MIX_W'(ANG_MIN);

    // Clamp a rounded blend result to the estimate range
    function automatic t_est sat_angle(input logic signed [MIX_W-1:0] v);
        t_est res;
        priority if (v > SAT_HI) begin
            res = t_est'(ANG_MAX);
        end else if (v < SAT_LO) begin
            res = t_est'(ANG_MIN);
        end else begin
            res = v[ANG_W-1:0];
        end
        return res;
    endfunction

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [2:0]               r_cnt;
    logic [2:0]               n_cnt;
    logic                     r_start;
    logic                     r_root_ok;
    logic                     r_roll_ok;
    logic                     r_out_valid;
    logic [CFG_W-1:0]         r_gyro_scale;
    logic [CFG_W-1:0]         r_blend_weight;
    t_est                     r_pitch_est;
    t_est                     r_roll_est;

    logic signed [IN_W-1:0]   r_ax;
    logic signed [IN_W-1:0]   r_ay;
    logic signed [IN_W-1:0]   r_az;
    logic signed [IN_W-1:0]   r_gx;
    logic signed [IN_W-1:0]   r_gy;
    logic signed [MUL_P_W-1:0] r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic signed [G_W-1:0]    r_gterm_p;
    logic signed [G_W-1:0]    r_gterm_r;
    t_angle                   r_acc_p;
    t_angle                   r_acc_r;
    logic signed [D_W-1:0]    r_diff_p;
    logic signed [D_W-1:0]    r_diff_r;
    logic signed [MIX_W-1:0]  r_mix_p;
    logic signed [MIX_W-1:0]  r_mix_r;
    t_est                     r_out_pitch;
    t_est                     r_out_roll;

    logic [2:0]               w_mop;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic                     w_cordic_done;
    t_angle                   w_angle;
    t_cordic_in               w_cy;
    t_cordic_in               w_cx;
    logic                     w_root_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_cfg_wr;
    logic signed [MIX_W-1:0]  w_pitch_sh;
    logic signed [MIX_W-1:0]  w_roll_sh;
    t_est                     w_pitch_new;
    t_est                     w_roll_new;

    // Handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    // Register read-back
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_GYRO_SCALE:   prdata = APB_DATA_W'(r_gyro_scale);
                REG_BLEND_WEIGHT: prdata = APB_DATA_W'(r_blend_weight);
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == MAC_LAST) begin
                    n_state = S_ROOT;
                    n_cnt   = '0;
                end
            end
            S_ROOT: begin
                if ((r_roll_ok || w_cordic_done) && (r_root_ok || w_root_done)) begin
                    n_state = S_PITCH;
                end
            end
            S_PITCH: begin
                if (w_cordic_done) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = S_BLEND;
                n_cnt   = '0;
            end
            S_BLEND: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == MAC_LAST) begin
                    n_state = S_ROUND;
                    n_cnt   = '0;
                end
            end
            S_ROUND: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_start        <= 1'b0;
            r_root_ok      <= 1'b0;
            r_roll_ok      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_gyro_scale   <= GYRO_SCALE_RST;
            r_blend_weight <= BLEND_WEIGHT_RST;
            r_pitch_est    <= '0;
            r_roll_est     <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_start   <= (n_state != r_state) && ((n_state == S_ROOT) || (n_state == S_PITCH));
            r_root_ok <= (r_state == S_ROOT) && (r_root_ok || w_root_done);
            r_roll_ok <= (r_state == S_ROOT) && (r_roll_ok || w_cordic_done);

            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_GYRO_SCALE:   r_gyro_scale   <= pwdata[CFG_W-1:0];
                    REG_BLEND_WEIGHT: r_blend_weight <= pwdata[CFG_W-1:0];
                endcase
            end

            if ((r_state == S_ROUND) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_pitch_est <= w_pitch_new;
                r_roll_est  <= w_roll_new;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared multiplier operand selection
    assign w_mop = {r_state == S_BLEND, r_cnt[1:0]};

    always_comb begin
        unique case (w_mop)
            MOP_AX_SQ: begin
                w_mul_a = MUL_A_W'(r_ax);
                w_mul_b = MUL_B_W'(r_ax);
            end
            MOP_AZ_SQ: begin
                w_mul_a = MUL_A_W'(r_az);
                w_mul_b = MUL_B_W'(r_az);
            end
            MOP_GY_SCALE: begin
                w_mul_a = MUL_A_W'(r_gy);
                w_mul_b = MUL_B_W'(r_gyro_scale);
            end
            MOP_GX_SCALE: begin
                w_mul_a = MUL_A_W'(r_gx);
                w_mul_b = MUL_B_W'(r_gyro_scale);
            end
            MOP_DL_PITCH: begin
                w_mul_a = MUL_A_W'(r_blend_weight);
                w_mul_b = MUL_B_W'(r_diff_p[D_LO_W-1:0]);
            end
            MOP_DH_PITCH: begin
                w_mul_a = MUL_A_W'(r_blend_weight);
                w_mul_b = MUL_B_W'($signed(r_diff_p[D_W-1:D_LO_W]));
            end
            MOP_DL_ROLL: begin
                w_mul_a = MUL_A_W'(r_blend_weight);
                w_mul_b = MUL_B_W'(r_diff_r[D_LO_W-1:0]);
            end
            MOP_DH_ROLL: begin
                w_mul_a = MUL_A_W'(r_blend_weight);
                w_mul_b = MUL_B_W'($signed(r_diff_r[D_W-1:D_LO_W]));
            end
        endcase
    end

    // CORDIC operands: roll vector first, pitch vector once the root is known
    always_comb begin
        if (r_state == S_PITCH) begin
            w_cy = CIN_W'(r_ay);
            w_cx = CIN_W'(w_root);
        end else begin
            w_cy = -CIN_W'(r_ax);
            w_cx = CIN_W'(r_az);
        end
    end

    ictf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start && (r_state == S_ROOT)),
        .i_value (r_sum),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    ictf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_y     (w_cy),
        .i_x     (w_cx),
        .o_done  (w_cordic_done),
        .o_angle (w_angle)
    );

    // Rounding half up and saturation of both blends
    assign w_pitch_sh  = (r_mix_p + RND_HALF) >>> RND_SH;
    assign w_roll_sh   = (r_mix_r + RND_HALF) >>> RND_SH;
    assign w_pitch_new = sat_angle(w_pitch_sh);
    assign w_roll_new  = sat_angle(w_roll_sh);

    // Datapath registers; the product of each step is registered and used by the following step
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;

        if (w_accept) begin
            r_ax <= s_axis_tdata[IN_W-1:0];
            r_ay <= s_axis_tdata[2*IN_W-1:IN_W];
            r_az <= s_axis_tdata[3*IN_W-1:2*IN_W];
            r_gx <= s_axis_tdata[4*IN_W-1:3*IN_W];
            r_gy <= s_axis_tdata[5*IN_W-1:4*IN_W];
        end

        if (r_state == S_MUL) begin
            unique case (r_cnt)
                3'd1:    r_sum <= r_prod[SUM_W-1:0];
                3'd2:    r_sum <= r_sum + r_prod[SUM_W-1:0];
                3'd3:    r_gterm_p <= (G_W'(r_pitch_est) <<< GYRO_SHIFT) + G_W'(r_prod);
                3'd4:    r_gterm_r <= (G_W'(r_roll_est) <<< GYRO_SHIFT) + G_W'(r_prod);
                default: ;
            endcase
        end

        if ((r_state == S_ROOT) && w_cordic_done) begin
            r_acc_r <= w_angle;
        end
        if ((r_state == S_PITCH) && w_cordic_done) begin
            r_acc_p <= w_angle;
        end

        // Blend as acc + w*(g - acc), all in Q.32 after the weight
        if (r_state == S_DIFF) begin
            r_diff_p <= D_W'(r_gterm_p) - D_W'(r_acc_p);
            r_diff_r <= D_W'(r_gterm_r) - D_W'(r_acc_r);
            r_mix_p  <= MIX_W'(r_acc_p) <<< Q16_FRAC;
            r_mix_r  <= MIX_W'(r_acc_r) <<< Q16_FRAC;
        end

        if (r_state == S_BLEND) begin
            unique case (r_cnt)
                3'd1:    r_mix_p <= r_mix_p + MIX_W'(r_prod);
                3'd2:    r_mix_p <= r_mix_p + (MIX_W'(r_prod) <<< D_LO_W);
                3'd3:    r_mix_r <= r_mix_r + MIX_W'(r_prod);
                3'd4:    r_mix_r <= r_mix_r + (MIX_W'(r_prod) <<< D_LO_W);
                default: ;
            endcase
        end

        if ((r_state == S_ROUND) && w_out_free) begin
            r_out_pitch <= w_pitch_new;
            r_out_roll  <= w_roll_new;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_roll, r_out_pitch};

    // An accepted sample always starts the multiply phase at its first step.
    `ICTF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, (r_state == S_MUL) && (r_cnt == 3'd0))
    // The CORDIC unit only finishes while the sequencer waits for it.
    `ICTF_ASSERT_NOW(a_cordic_done_state, i_clk, i_rst_n, w_cordic_done, (r_state == S_ROOT) || (r_state == S_PITCH))
    // The square root only finishes during the root phase.
    `ICTF_ASSERT_NOW(a_root_done_state, i_clk, i_rst_n, w_root_done, r_state == S_ROOT)
    // A finished blend is published and the sequencer returns to idle.
    `ICTF_ASSERT_NEXT(a_round_publishes, i_clk, i_rst_n, (r_state == S_ROUND) && w_out_free, r_out_valid && (r_state == S_IDLE))

endmodule

// ----- test/imu_complementary_tilt_filter_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// imu_complementary_tilt_filter_tb
// Drives raw IMU samples into the tilt filter and checks every pitch/roll
// result against an in-bench fixed-point predictor. Registers are written
// between phases, the sink stalls at random and once for a long stretch.
// ============================================================================
module imu_complementary_tilt_filter_tb;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int STEP_COUNT      = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int DRAIN_CYCLES    = 2 * CORDIC_STEPS + 16 + 24;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 148;
    localparam longint ANGLE_HI    = 8388607;
    localparam longint ANGLE_LO    = -8388608;

    // atan(2^-i) in degrees, Q.16
    localparam longint ATAN_DEG_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // One raw sample, accel_x in the lowest bits.
    typedef struct packed {
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } t_sample;

    // One filter result, pitch in the lowest bits.
    typedef struct packed {
        logic signed [23:0] roll;
        logic signed [23:0] pitch;
    } t_angle_pair;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y (16 bits each, lowest first)
    logic [ictf_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // pitch_angle, roll_angle (24 bits each, lowest first)
    logic [ictf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ictf_pkg::APB_ADDR_W-1:0] paddr;
    logic [ictf_pkg::APB_DATA_W-1:0] pwdata;
    logic [ictf_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    logic tx_idle_on = 1'b0;
    logic rx_idle_on = 1'b0;
    logic hold_request = 1'b0;

    // ------------------------------------------------------------------------
    // Tilt predictor and store of expected angle pairs
    // ------------------------------------------------------------------------
    class t_tilt_scoreboard;
        logic [15:0]        gyro_scale;
        logic [15:0]        blend_weight;
        logic signed [23:0] pitch_est;
        logic signed [23:0] roll_est;
        t_angle_pair        expected_angles[$];
        int unsigned        mismatches;

        function new();
            gyro_scale   = ictf_pkg::GYRO_SCALE_RST;
            blend_weight = ictf_pkg::BLEND_WEIGHT_RST;
            pitch_est    = '0;
            roll_est     = '0;
            mismatches   = 0;
        endfunction

        function void load_register(input logic idx, input logic [15:0] value);
            if (idx == ictf_pkg::REG_GYRO_SCALE)
                gyro_scale = value;
            else
                blend_weight = value;
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        // Floor integer square root of a 32-bit sum of squares.
        function logic [31:0] root_floor(input logic [31:0] v);
            logic [31:0] rem;
            logic [31:0] res;
            logic [31:0] probe;
            rem   = v;
            res   = '0;
            probe = 32'h4000_0000;
            while (probe > rem)
                probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= res + probe) begin
                    rem = rem - (res + probe);
                    res = (res >> 1) + probe;
                end else begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
            return res;
        endfunction

        // CORDIC vectoring atan2(y, x), Q.16 degrees.
        function longint vector_angle(input longint yin, input longint xin);
            longint x;
            longint y;
            longint z;
            longint t;
            longint xs;
            longint ys;
            if (xin == 0 && yin == 0)
                return 0;
            x = xin * 16384;
            y = yin * 16384;
            z = 0;
            // Left half plane: turn by a quarter first.
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 90 * 65536;
                end else begin
                    t = x; x = -y; y = t; z = -90 * 65536;
                end
            end
            for (int i = 0; i < STEP_COUNT; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z = z + ATAN_DEG_Q16[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - ATAN_DEG_Q16[i];
                end
            end
            return z;
        endfunction

        // Weighted mix of the gyro-integrated angle and the accel angle.
        function logic signed [23:0] mix_angle(input logic signed [23:0] est,
                                               input logic signed [15:0] rate,
                                               input longint accel_q16);
            longint g;
            longint w;
            longint mix;
            longint r;
            int     sh;
            sh  = 32 - ANGLE_FRAC_BITS;
            g   = longint'(est) * (longint'(1) << (16 - ANGLE_FRAC_BITS))
                + longint'(rate) * longint'(gyro_scale);
            w   = longint'(blend_weight);
            mix = w * g + (65536 - w) * accel_q16;
            r   = (mix + (longint'(1) << (sh - 1))) >>> sh;
            if (r > ANGLE_HI)
                r = ANGLE_HI;
            if (r < ANGLE_LO)
                r = ANGLE_LO;
            return r[23:0];
        endfunction

        // Advance the estimates by one accepted sample.
        function void note_sample(input t_sample s);
            longint      ax;
            longint      az;
            longint      sq;
            logic [31:0] sum;
            longint      accel_pitch;
            longint      accel_roll;
            t_angle_pair next;
            ax          = longint'(s.accel_x);
            az          = longint'(s.accel_z);
            sq          = ax * ax + az * az;
            sum         = sq[31:0];
            accel_pitch = vector_angle(longint'(s.accel_y), longint'(root_floor(sum)));
            accel_roll  = vector_angle(-ax, az);
            pitch_est   = mix_angle(pitch_est, s.gyro_y, accel_pitch);
            roll_est    = mix_angle(roll_est, s.gyro_x, accel_roll);
            next.pitch  = pitch_est;
            next.roll   = roll_est;
            expected_angles.push_back(next);
        endfunction

        function void check_result(input t_angle_pair got);
            t_angle_pair want;
            if (expected_angles.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: pitch %0d roll %0d", got.pitch, got.roll);
                mismatches++;
                return;
            end
            want = expected_angles.pop_front();
            if (got.pitch !== want.pitch || got.roll !== want.roll) begin
                if (mismatches < 10)
                    $display("angle mismatch: pitch exp %0d got %0d, roll exp %0d got %0d",
                             want.pitch, got.pitch, want.roll, got.roll);
                mismatches++;
            end
        endfunction
    endclass

    t_tilt_scoreboard sb = new();

    imu_complementary_tilt_filter #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Observe accepted requests on both stream sides.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Result sink: random stall bursts, and one long hold-off on request.
    initial begin : result_sink
        int k;
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 4);
                m_axis_tready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no accepted request or register access.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_sample make_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy);
        t_sample s;
        s.accel_x = ax[15:0];
        s.accel_y = ay[15:0];
        s.accel_z = az[15:0];
        s.gyro_x  = gx[15:0];
        s.gyro_y  = gy[15:0];
        return s;
    endfunction

    // Raw count with weight on extremes, small values and gravity-like levels.
    function automatic logic [15:0] pick_raw();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'($urandom_range(0, 400) - 200);
            4: v = 16'($urandom_range(15000, 17800));
            5: v = 16'(-$signed($urandom_range(15000, 17800)));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.accel_x = pick_raw();
        s.accel_y = pick_raw();
        s.accel_z = pick_raw();
        s.gyro_x  = pick_raw();
        s.gyro_y  = pick_raw();
        return s;
    endfunction

    // Offer one sample request and wait until it is taken.
    task automatic send_sample(input t_sample s);
        int k;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            k = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= ictf_pkg::IN_TDATA_W'({$urandom, $urandom, $urandom});
            repeat (k) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    // The first edge lets the monitor note the last accepted sample.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup cycle, access cycle until pready, then back to idle.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.load_register(idx, value);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] scale;
        logic [15:0] weight;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Reset defaults: zero vectors, extremes and every CORDIC quadrant.
        send_sample(make_sample(0, 0, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(0, 1000, 0, 0, 0));
        send_sample(make_sample(0, -32768, 0, 0, 0));
        send_sample(make_sample(-32768, 200, 0, 10, -10));
        send_sample(make_sample(5000, 0, -16384, 0, 0));
        send_sample(make_sample(-5000, 0, -16384, 0, 0));
        send_sample(make_sample(0, 0, -16384, 0, 0));
        send_sample(make_sample(0, 0, 16384, 0, 0));
        settle();

        // Full gyro scale and weight: drive both estimates into saturation.
        write_reg(ictf_pkg::REG_GYRO_SCALE, 16'hFFFF);
        write_reg(ictf_pkg::REG_BLEND_WEIGHT, 16'hFFFF);
        repeat (4) send_sample(make_sample(0, 0, 16384, 32767, 32767));
        repeat (6) send_sample(make_sample(0, 0, 16384, -32768, -32768));
        settle();

        // Smallest scale and zero weight: accelerometer angle only.
        write_reg(ictf_pkg::REG_GYRO_SCALE, 16'd1);
        write_reg(ictf_pkg::REG_BLEND_WEIGHT, 16'd0);
        repeat (3) send_sample(random_sample());
        settle();

        // Random phases with fresh register settings each time.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: scale = 16'd1;
                1: scale = 16'hFFFF;
                default: scale = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: weight = 16'd0;
                1: weight = 16'hFFFF;
                default: weight = 16'($urandom_range(0, 65535));
            endcase
            write_reg(ictf_pkg::REG_GYRO_SCALE, scale);
            write_reg(ictf_pkg::REG_BLEND_WEIGHT, weight);
            if (p == 1)
                hold_request = 1'b1;
            if (p == RANDOM_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) send_sample(random_sample());
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- imu_complementary_tilt_filter.f -----
+incdir+design
design/ictf_pkg.sv
design/ictf_isqrt.sv
design/ictf_cordic.sv
design/imu_complementary_tilt_filter.sv
test/imu_complementary_tilt_filter_tb.sv
